[hdl/mvbc_pkg.sv]
package mvbc_pkg;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_CH_WR,
    ST_V_RD,
    ST_V_ADD,
    ST_V_REF,
    ST_V_ADR,
    ST_V_TAP,
    ST_V_DIF,
    ST_V_LPM,
    ST_V_ACC,
    ST_M_WLO,
    ST_M_WHI,
    ST_M_DRY,
    ST_M_SUM,
    ST_M_SHF,
    ST_G_LO,
    ST_G_HI,
    ST_G_SUM,
    ST_G_RND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        [31:0] pos;
    logic signed [17:0] rate;
    logic        [15:0] amp;
    logic signed [31:0] filt;
  } voice_t;

  localparam int VOICE_W = $bits(voice_t);

  localparam logic [1:0] ACT_FRAME = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_RATE  = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam logic [2:0] REG_SPAN  = 3'd0;
  localparam logic [2:0] REG_COUNT = 3'd1;
  localparam logic [2:0] REG_COEFF = 3'd2;
  localparam logic [2:0] REG_WET   = 3'd3;
  localparam logic [2:0] REG_GAIN  = 3'd4;

  localparam logic signed [17:0] RATE_MIN = -18'sd131072;
  localparam logic signed [17:0] RATE_MAX = 18'sd131071;
  localparam logic signed [23:0] SMP_MAX  = 24'sd8388607;
  localparam logic signed [23:0] SMP_MIN  = -24'sd8388608;
  localparam logic        [16:0] UNITY    = 17'd65536;

endpackage

[hdl/mvbc_ram.sv]
module mvbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/multivoice_bouncing_chorus.sv]
// Stereo chorus with bouncing delay taps, one shared multiplier.
// Input channel (in_valid / in_stall): action 0 is an audio frame carrying a
// left and right sample; action 1 loads a voice (position, rate, level);
// action 2 sets a voice rate only. Only frames produce a transfer on the
// output channel (out_valid / out_stall) carrying out_left and out_right.
// Configuration registers are written over the APB-style cfg_ port; the user
// must do so only while the block is idle (not enforced); pready is always high.
// A frame runs, per channel, a ring write, then per active voice the steps
// read, add, reflect, address, tap, difference, low-pass and accumulate,
// then the mix and gain steps, all sharing one 35x18 multiplier and the
// single voice memory port. Load and set-rate items read and write the voice
// entry. One item is in work at a time; in_stall is high until it is finished.
// After reset the delay rings and voice memory are swept to zero, one entry
// per cycle, across all 2*BUFFER_DEPTH ring entries; no item is taken meanwhile.
// A finished frame result waits in the output register while out_stall is
// high; the block holds before its last step until that result has gone,
// and a new item is taken as soon as the result is registered.
// BUFFER_DEPTH must be a power of two.
module multivoice_bouncing_chorus
  import mvbc_pkg::*;
#(
  parameter int BUFFER_DEPTH = 65536,
  parameter int MAX_VOICES   = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [23:0] in_sample_left,
  input  logic signed [23:0] in_sample_right,
  input  logic [7:0]         in_voice_index,
  input  logic               in_channel_index,
  input  logic [31:0]        in_start_position,
  input  logic signed [17:0] in_step_rate,
  input  logic [15:0]        in_voice_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_left,
  output logic signed [23:0] out_right,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int WW = 33 + VW;

  state_t state_r, state_nxt;

  logic [15:0] span_r;
  logic [8:0]  count_r;
  logic [15:0] coeff_r;
  logic [16:0] wet_mix_r;
  logic [15:0] gain_r;

  logic [AW:0]   clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic          ch_r, ch_nxt;
  logic [VW-1:0] j_r, j_nxt;

  logic [1:0]         act_r, act_nxt;
  logic signed [23:0] smp_l_r, smp_l_nxt, smp_rt_r, smp_rt_nxt;
  logic [7:0]         vi_r, vi_nxt;
  logic               vch_r, vch_nxt;
  logic [31:0]        spos_r, spos_nxt;
  logic signed [17:0] srate_r, srate_nxt;
  logic [15:0]        slev_r, slev_nxt;

  logic signed [17:0] rate_r, rate_nxt, rate_n_r, rate_n_nxt;
  logic [15:0]        amp_r, amp_nxt;
  logic signed [31:0] lp_r, lp_nxt;
  logic signed [33:0] d_r, d_nxt;
  logic [31:0]        pos_n_r, pos_n_nxt;
  logic signed [32:0] diff_r, diff_nxt;
  logic signed [52:0] prod_r, prod_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [WW-1:0] wet_r, wet_nxt;
  logic signed [47:0] mix_r, mix_nxt;
  logic signed [23:0] res_l_r, res_l_nxt, res_rt_r, res_rt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [23:0] out_left_r, out_left_nxt, out_right_r, out_right_nxt;

  logic signed [34:0] mul_a;
  logic signed [17:0] mul_b;

  logic                 ring_we;
  logic [AW:0]          ring_waddr, ring_raddr;
  logic [23:0]          ring_wdata, ring_rdata;
  logic                 vr_we;
  logic [VW:0]          vr_waddr, vr_raddr;
  logic [VOICE_W-1:0]   vr_wdata, vr_rdata;
  voice_t               vrd, vwr;

  logic                 in_take, cfg_we, out_free, last_voice;
  logic [VW:0]          active;
  logic [16:0]          m_wet, m_dry;
  logic signed [23:0]   smp;
  logic signed [33:0]   lim, dref;
  logic signed [31:0]   tap, lpn;
  logic signed [63:0]   rnd, shr;
  logic signed [23:0]   res;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign out_free   = !out_valid_r || !out_stall;
  assign out_valid  = out_valid_r;
  assign out_left   = out_left_r;
  assign out_right  = out_right_r;

  assign active = (32'(count_r) > MAX_VOICES) ? (VW+1)'(MAX_VOICES) : (VW+1)'(count_r);
  assign last_voice = ({1'b0, j_r} == active - 1'b1);
  assign m_wet = (wet_mix_r > UNITY) ? UNITY : wet_mix_r;
  assign m_dry = UNITY - m_wet;
  assign smp   = ch_r ? smp_rt_r : smp_l_r;
  assign lim   = $signed({2'b00, span_r, 16'h0000});
  assign vrd   = voice_t'(vr_rdata);
  assign vr_wdata = vwr;
  assign tap   = $signed(prod_r[39:8]);
  assign lpn   = lp_r + 32'(prod_r >>> 16);
  assign rnd   = acc_r + 64'sd524288;
  assign shr   = rnd >>> 20;
  assign res   = (shr > 64'(SMP_MAX)) ? SMP_MAX :
                 (shr < 64'(SMP_MIN)) ? SMP_MIN : shr[23:0];
  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    case (cfg_paddr[4:2])
      REG_SPAN:  cfg_prdata = {16'h0, span_r};
      REG_COUNT: cfg_prdata = {23'h0, count_r};
      REG_COEFF: cfg_prdata = {16'h0, coeff_r};
      REG_WET:   cfg_prdata = {15'h0, wet_mix_r};
      REG_GAIN:  cfg_prdata = {16'h0, gain_r};
      default:   cfg_prdata = 32'h0;
    endcase
  end

  // Reflection at zero and at the span, then clamp.
  always_comb begin
    rate_n_nxt = rate_n_r;
    if (d_r < 0) begin
      dref = -d_r;
    end else if (d_r >= lim) begin
      dref = (lim <<< 1) - d_r;
    end else begin
      dref = d_r;
    end
    if (d_r < 0 || d_r >= lim) begin
      rate_n_nxt = (rate_r == RATE_MIN) ? RATE_MAX : -rate_r;
    end else begin
      rate_n_nxt = rate_r;
    end
    if (dref < 0) begin
      pos_n_nxt = 32'h0;
    end else if (dref > lim) begin
      pos_n_nxt = lim[31:0];
    end else begin
      pos_n_nxt = dref[31:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == '1) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_take) begin
          case (in_action)
            ACT_FRAME: state_nxt = ST_CH_WR;
            ACT_LOAD, ACT_RATE: begin
              if (32'(in_voice_index) < MAX_VOICES) state_nxt = ST_LD_RD;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LD_RD: state_nxt = ST_LD_WR;
      ST_LD_WR: state_nxt = ST_IDLE;
      ST_CH_WR: state_nxt = (active == '0) ? ST_M_WLO : ST_V_RD;
      ST_V_RD:  state_nxt = ST_V_ADD;
      ST_V_ADD: state_nxt = ST_V_REF;
      ST_V_REF: state_nxt = ST_V_ADR;
      ST_V_ADR: state_nxt = ST_V_TAP;
      ST_V_TAP: state_nxt = ST_V_DIF;
      ST_V_DIF: state_nxt = ST_V_LPM;
      ST_V_LPM: state_nxt = ST_V_ACC;
      ST_V_ACC: state_nxt = last_voice ? ST_M_WLO : ST_V_RD;
      ST_M_WLO: state_nxt = ST_M_WHI;
      ST_M_WHI: state_nxt = ST_M_DRY;
      ST_M_DRY: state_nxt = ST_M_SUM;
      ST_M_SUM: state_nxt = ST_M_SHF;
      ST_M_SHF: state_nxt = ST_G_LO;
      ST_G_LO:  state_nxt = ST_G_HI;
      ST_G_HI:  state_nxt = ST_G_SUM;
      ST_G_SUM: state_nxt = ST_G_RND;
      ST_G_RND: state_nxt = ch_r ? ST_DONE : ST_CH_WR;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory ports
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    wp_nxt      = wp_r;
    ch_nxt      = ch_r;
    j_nxt       = j_r;
    act_nxt     = act_r;
    smp_l_nxt   = smp_l_r;
    smp_rt_nxt  = smp_rt_r;
    vi_nxt      = vi_r;
    vch_nxt     = vch_r;
    spos_nxt    = spos_r;
    srate_nxt   = srate_r;
    slev_nxt    = slev_r;
    rate_nxt    = rate_r;
    amp_nxt     = amp_r;
    lp_nxt      = lp_r;
    d_nxt       = d_r;
    diff_nxt    = diff_r;
    acc_nxt     = acc_r;
    wet_nxt     = wet_r;
    mix_nxt     = mix_r;
    res_l_nxt   = res_l_r;
    res_rt_nxt  = res_rt_r;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_valid_nxt = out_valid_r && out_stall;
    mul_a      = '0;
    mul_b      = '0;
    ring_we    = 1'b0;
    ring_waddr = '0;
    ring_wdata = '0;
    ring_raddr = '0;
    vr_we      = 1'b0;
    vr_waddr   = '0;
    vr_raddr   = '0;
    vwr        = '0;

    case (state_r)
      ST_CLEAR: begin
        ring_we     = 1'b1;
        ring_waddr  = clr_cnt_r;
        vr_we       = (32'(clr_cnt_r) < (2 << VW));
        vr_waddr    = clr_cnt_r[VW:0];
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_take) begin
          act_nxt    = in_action;
          smp_l_nxt  = in_sample_left;
          smp_rt_nxt = in_sample_right;
          vi_nxt     = in_voice_index;
          vch_nxt    = in_channel_index;
          spos_nxt   = in_start_position;
          srate_nxt  = in_step_rate;
          slev_nxt   = in_voice_level;
          ch_nxt     = 1'b0;
        end
      end
      ST_LD_RD: vr_raddr = {vch_r, VW'(vi_r)};
      ST_LD_WR: begin
        vwr      = vrd;
        vwr.rate = srate_r;
        if (act_r == ACT_LOAD) begin
          vwr.pos = spos_r;
          vwr.amp = slev_r;
        end
        vr_we    = 1'b1;
        vr_waddr = {vch_r, VW'(vi_r)};
      end
      ST_CH_WR: begin
        ring_we    = 1'b1;
        ring_waddr = {ch_r, wp_r};
        ring_wdata = smp;
        wet_nxt    = '0;
        j_nxt      = '0;
      end
      ST_V_RD: vr_raddr = {ch_r, j_r};
      ST_V_ADD: begin
        rate_nxt = vrd.rate;
        amp_nxt  = vrd.amp;
        lp_nxt   = vrd.filt;
        d_nxt    = $signed({2'b00, vrd.pos}) + 34'(vrd.rate);
      end
      ST_V_ADR: ring_raddr = {ch_r, wp_r - AW'(pos_n_r[31:16])};
      ST_V_TAP: begin
        mul_a = 35'($signed(ring_rdata));
        mul_b = $signed({2'b00, amp_r});
      end
      ST_V_DIF: diff_nxt = 33'(tap) - 33'(lp_r);
      ST_V_LPM: begin
        mul_a = 35'(diff_r);
        mul_b = $signed({2'b00, coeff_r});
      end
      ST_V_ACC: begin
        vwr.pos  = pos_n_r;
        vwr.rate = rate_n_r;
        vwr.amp  = amp_r;
        vwr.filt = lpn;
        vr_we    = 1'b1;
        vr_waddr = {ch_r, j_r};
        wet_nxt  = wet_r + WW'(lpn);
        if (!last_voice) j_nxt = j_r + 1'b1;
      end
      ST_M_WLO: begin
        mul_a = $signed({11'h0, wet_r[23:0]});
        mul_b = $signed({1'b0, m_wet});
      end
      ST_M_WHI: begin
        acc_nxt = 64'(prod_r);
        mul_a   = 35'($signed(wet_r[WW-1:24]));
        mul_b   = $signed({1'b0, m_wet});
      end
      ST_M_DRY: begin
        acc_nxt = acc_r + (64'(prod_r) <<< 24);
        mul_a   = 35'(smp);
        mul_b   = $signed({1'b0, m_dry});
      end
      ST_M_SUM: acc_nxt = acc_r + (64'(prod_r) <<< 8);
      ST_M_SHF: mix_nxt = acc_r[63:16];
      ST_G_LO: begin
        mul_a = $signed({11'h0, mix_r[23:0]});
        mul_b = $signed({2'b00, gain_r});
      end
      ST_G_HI: begin
        acc_nxt = 64'(prod_r);
        mul_a   = 35'($signed(mix_r[47:24]));
        mul_b   = $signed({2'b00, gain_r});
      end
      ST_G_SUM: acc_nxt = acc_r + (64'(prod_r) <<< 24);
      ST_G_RND: begin
        if (ch_r) begin
          res_rt_nxt = res;
        end else begin
          res_l_nxt = res;
          ch_nxt    = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = res_l_r;
          out_right_nxt = res_rt_r;
          wp_nxt        = wp_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      span_r      <= 16'd960;
      count_r     <= 9'd50;
      coeff_r     <= 16'd64880;
      wet_mix_r   <= 17'd65536;
      gain_r      <= 16'd4096;
      clr_cnt_r   <= '0;
      wp_r        <= '0;
      ch_r        <= 1'b0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      wp_r        <= wp_nxt;
      ch_r        <= ch_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_paddr[4:2])
          REG_SPAN:  span_r    <= cfg_pwdata[15:0];
          REG_COUNT: count_r   <= cfg_pwdata[8:0];
          REG_COEFF: coeff_r   <= cfg_pwdata[15:0];
          REG_WET:   wet_mix_r <= cfg_pwdata[16:0];
          REG_GAIN:  gain_r    <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    smp_l_r  <= smp_l_nxt;
    smp_rt_r <= smp_rt_nxt;
    vi_r     <= vi_nxt;
    vch_r    <= vch_nxt;
    spos_r   <= spos_nxt;
    srate_r  <= srate_nxt;
    slev_r   <= slev_nxt;
    rate_r   <= rate_nxt;
    amp_r    <= amp_nxt;
    lp_r     <= lp_nxt;
    d_r      <= d_nxt;
    pos_n_r  <= pos_n_nxt;
    rate_n_r <= rate_n_nxt;
    diff_r   <= diff_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    wet_r    <= wet_nxt;
    mix_r    <= mix_nxt;
    res_l_r  <= res_l_nxt;
    res_rt_r <= res_rt_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
  end

  mvbc_ram #(.WIDTH(24), .DEPTH(2 << AW)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  mvbc_ram #(.WIDTH(VOICE_W), .DEPTH(2 << VW)) u_voice (
    .clk   (clk),
    .we    (vr_we),
    .waddr (vr_waddr),
    .wdata (vr_wdata),
    .raddr (vr_raddr),
    .rdata (vr_rdata)
  );

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the final step");

  a_ring_write: assert property (@(posedge clk) disable iff (!rst_n)
    ring_we |-> (state_r == ST_CLEAR || state_r == ST_CH_WR))
    else $error("unexpected ring write");

  a_voice_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_V_RD |-> ({1'b0, j_r} < active))
    else $error("voice index beyond active count");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_V_ADR |-> ({2'b00, pos_n_r} <= lim))
    else $error("voice position beyond span");

  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |=> (state_r == ST_CLEAR || state_r == ST_IDLE))
    else $error("left clearing pass early");
`endif

endmodule

[test/multivoice_bouncing_chorus_tb.sv]
`timescale 1ns / 100ps

module multivoice_bouncing_chorus_tb;
  import mvbc_pkg::*;

  localparam int RING = 65536;
  localparam int VOICES = 256;

  typedef struct {
    logic [1:0]         act;
    logic signed [23:0] sl;
    logic signed [23:0] sr;
    logic [7:0]         vi;
    logic               ch;
    logic [31:0]        pos;
    logic signed [17:0] rate;
    logic [15:0]        lvl;
    bit                 typed;
    logic signed [23:0] el;
    logic signed [23:0] er;
  } chorus_item_t;

  typedef struct {
    logic signed [23:0] l;
    logic signed [23:0] r;
  } stereo_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = ACT_FRAME;
  logic signed [23:0] in_sample_left = '0;
  logic signed [23:0] in_sample_right = '0;
  logic [7:0] in_voice_index = '0;
  logic in_channel_index = 1'b0;
  logic [31:0] in_start_position = '0;
  logic signed [17:0] in_step_rate = '0;
  logic [15:0] in_voice_level = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] out_left;
  logic signed [23:0] out_right;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  multivoice_bouncing_chorus DUT (.*);

  always #1 clk = ~clk;

  // chorus state mirror
  int span_q, count_q, coeff_q, wet_q, gain_q;
  int ring_smp[2*RING];
  bit [31:0] v_pos[2*VOICES];
  int v_rate[2*VOICES];
  int v_amp[2*VOICES];
  int v_filt[2*VOICES];
  int wr_ptr;

  stereo_t frame_q[$];
  int errors = 0;
  int frames_checked = 0;
  int voice_updates = 0;
  bit idling = 1'b1;
  bit long_hold = 1'b0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int flip_rate(input int r);
    return (r <= int'(RATE_MIN)) ? int'(RATE_MAX) : -r;
  endfunction

  function automatic logic signed [23:0] chorus_channel(input int ch, input longint smp);
    longint lim, wet, d, tap, lp, m, mixed, y;
    int active, idx, back, addr;
    lim = longint'(span_q) <<< 16;
    wet = 0;
    active = (count_q > VOICES) ? VOICES : count_q;
    for (int j = 0; j < active; j++) begin
      idx = ch * VOICES + j;
      d = longint'(v_pos[idx]) + longint'(v_rate[idx]);
      if (d < 0) begin
        d = -d;
        v_rate[idx] = flip_rate(v_rate[idx]);
      end else if (d >= lim) begin
        d = 2 * lim - d;
        v_rate[idx] = flip_rate(v_rate[idx]);
      end
      if (d < 0) d = 0;
      if (d > lim) d = lim;
      v_pos[idx] = d[31:0];
      back = int'((d >>> 16) % RING);
      addr = (wr_ptr + RING - back) % RING;
      tap = (longint'(ring_smp[ch * RING + addr]) * longint'(v_amp[idx])) >>> 8;
      lp = longint'(v_filt[idx]);
      lp = lp + (((tap - lp) * longint'(coeff_q)) >>> 16);
      v_filt[idx] = int'(lp[31:0]);
      wet += longint'(v_filt[idx]);
    end
    m = (wet_q > 65536) ? 65536 : longint'(wet_q);
    mixed = (wet * m + smp * 256 * (65536 - m)) >>> 16;
    y = (mixed * longint'(gain_q) + (longint'(1) <<< 19)) >>> 20;
    if (y > longint'(SMP_MAX)) y = SMP_MAX;
    if (y < longint'(SMP_MIN)) y = SMP_MIN;
    return y[23:0];
  endfunction

  // apply one accepted transfer to the mirror and note the expected frame
  task automatic predict_chorus(input chorus_item_t it);
    stereo_t res;
    int idx;
    case (it.act)
      ACT_FRAME: begin
        wr_ptr = wr_ptr % RING;
        ring_smp[wr_ptr] = int'(it.sl);
        res.l = chorus_channel(0, longint'(it.sl));
        ring_smp[RING + wr_ptr] = int'(it.sr);
        res.r = chorus_channel(1, longint'(it.sr));
        wr_ptr = (wr_ptr + 1) % RING;
        if (it.typed) begin
          res.l = it.el;
          res.r = it.er;
        end
        frame_q.push_back(res);
      end
      ACT_LOAD, ACT_RATE: begin
        idx = int'(it.ch) * VOICES + int'(it.vi);
        v_rate[idx] = int'(it.rate);
        if (it.act == ACT_LOAD) begin
          v_pos[idx] = it.pos;
          v_amp[idx] = int'(it.lvl);
        end
        voice_updates++;
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input chorus_item_t it);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= it.act;
    in_sample_left <= it.sl;
    in_sample_right <= it.sr;
    in_voice_index <= it.vi;
    in_channel_index <= it.ch;
    in_start_position <= it.pos;
    in_step_rate <= it.rate;
    in_voice_level <= it.lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_chorus(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_q.size() != 0) @(posedge clk);
    // a voice update may still be in work
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] reg_id, input int value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_id, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    case (reg_id)
      REG_SPAN: span_q = value & 32'hFFFF;
      REG_COUNT: count_q = value & 32'h1FF;
      REG_COEFF: coeff_q = value & 32'hFFFF;
      REG_WET: wet_q = value & 32'h1FFFF;
      REG_GAIN: gain_q = value & 32'hFFFF;
      default: ;
    endcase
  endtask

  task automatic set_chorus(input int span, input int cnt, input int coeff, input int wet,
                            input int gain);
    wait_idle();
    cfg_write(REG_SPAN, span);
    cfg_write(REG_COUNT, cnt);
    cfg_write(REG_COEFF, coeff);
    cfg_write(REG_WET, wet);
    cfg_write(REG_GAIN, gain);
  endtask

  function automatic chorus_item_t random_item();
    chorus_item_t it;
    int pick, active;
    active = (count_q > VOICES) ? VOICES : count_q;
    pick = $urandom_range(0, 19);
    it.typed = 1'b0;
    it.el = '0;
    it.er = '0;
    it.act = (pick < 12) ? ACT_FRAME : (pick < 16) ? ACT_LOAD : (pick < 19) ? ACT_RATE :
             ACT_SPARE;
    it.sl = $urandom();
    it.sr = $urandom();
    if ($urandom_range(0, 9) == 0) it.sl = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
    if ($urandom_range(0, 9) == 0) it.sr = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
    // mostly aim updates at voices that are in use
    if (active > 0 && $urandom_range(0, 7) != 0) it.vi = $urandom_range(0, active - 1);
    else it.vi = $urandom();
    it.ch = $urandom();
    if ($urandom_range(0, 3) != 0) it.pos = $urandom_range(0, span_q << 16);
    else it.pos = $urandom();
    case ($urandom_range(0, 3))
      0: it.rate = $urandom();
      1: it.rate = $urandom_range(0, 131072) - 65536;
      2: it.rate = $urandom_range(0, 8192) - 4096;
      default: it.rate = '0;
    endcase
    it.lvl = $urandom();
    return it;
  endfunction

  task automatic random_run(input int n);
    for (int i = 0; i < n; i++) send_item(random_item());
  endtask

  function automatic chorus_item_t row(input logic [1:0] act, input int sl, input int sr,
                                       input int vi, input bit ch, input logic [31:0] pos,
                                       input int rate, input int lvl, input bit typed);
    chorus_item_t it;
    it.act = act;
    it.sl = sl;
    it.sr = sr;
    it.vi = vi;
    it.ch = ch;
    it.pos = pos;
    it.rate = rate;
    it.lvl = lvl;
    it.typed = typed;
    it.el = '0;
    it.er = '0;
    return it;
  endfunction

  // results
  always @(posedge clk) begin
    stereo_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_q.size() == 0) begin
        report_mismatch("unexpected frame, left", out_left, 0);
      end else begin
        want = frame_q.pop_front();
        if (out_left !== want.l) report_mismatch("out_left", out_left, want.l);
        if (out_right !== want.r) report_mismatch("out_right", out_right, want.r);
        frames_checked++;
      end
    end
  end

  // receiver back-pressure
  initial begin
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        long_hold = 1'b0;
      end else if (idling && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    chorus_item_t directed[$];
    span_q = 960;
    count_q = 50;
    coeff_q = 64880;
    wet_q = 65536;
    gain_q = 4096;
    wr_ptr = 0;
    for (int i = 0; i < 2 * RING; i++) ring_smp[i] = 0;
    for (int i = 0; i < 2 * VOICES; i++) begin
      v_pos[i] = '0;
      v_rate[i] = 0;
      v_amp[i] = 0;
      v_filt[i] = 0;
    end

    // silent voices and a fully wet mix give zero out
    directed.push_back(row(ACT_FRAME, 8388607, -8388608, 0, 0, 0, 0, 0, 1));
    directed.push_back(row(ACT_FRAME, -8388608, 8388607, 0, 0, 0, 0, 0, 1));
    directed.push_back(row(ACT_SPARE, 123, 456, 7, 1, 32'hFFFF_FFFF, -1, 65535, 0));
    directed.push_back(row(ACT_FRAME, 0, 0, 0, 0, 0, 0, 0, 1));
    directed.push_back(row(ACT_LOAD, 0, 0, 0, 0, 0, 65536, 65535, 0));
    directed.push_back(row(ACT_LOAD, 0, 0, 1, 1, 32'hFBFF_FFFF, -65536, 32768, 0));
    directed.push_back(row(ACT_LOAD, 0, 0, 49, 0, 960 << 16, 131071, 65535, 0));
    directed.push_back(row(ACT_LOAD, 0, 0, 2, 1, 0, -131072, 65535, 0));
    directed.push_back(row(ACT_LOAD, 0, 0, 255, 0, 32'hFFFF_FFFF, -131072, 65535, 0));
    directed.push_back(row(ACT_LOAD, 0, 0, 3, 0, 5 << 16, 0, 0, 0));
    directed.push_back(row(ACT_RATE, 0, 0, 3, 0, 0, 1, 0, 0));
    directed.push_back(row(ACT_FRAME, 8388607, 8388607, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(ACT_FRAME, -8388608, -8388608, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(ACT_FRAME, 8388607, -8388608, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(ACT_RATE, 0, 0, 0, 0, 0, -65536, 0, 0));
    directed.push_back(row(ACT_RATE, 0, 0, 2, 1, 0, -131072, 0, 0));
    directed.push_back(row(ACT_FRAME, 1, -1, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(ACT_FRAME, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(ACT_FRAME, 4194304, -4194304, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(ACT_RATE, 0, 0, 255, 1, 0, 131071, 0, 0));
    directed.push_back(row(ACT_FRAME, -1, 1, 0, 0, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_item(directed[i]);

    // zero span, few voices; fill the block against a held receiver
    set_chorus(0, 3, 65535, 32768, 65535);
    long_hold = 1'b1;
    random_run(200);

    // a wide span of 64511, every voice, out-of-range count and wet mix, zero gain
    set_chorus(64511, 511, 0, 131071, 0);
    random_run(40);

    // no voices, dry only
    set_chorus(20, 0, 1, 0, 4096);
    random_run(150);

    set_chorus($urandom_range(1, 2000), 8, $urandom(), $urandom_range(0, 65536), 12000);
    random_run(400);
    idling = 1'b0;
    random_run(260);

    wait_idle();
    repeat (100) @(posedge clk);
    $display("run: %0d frames checked, %0d voice updates, 5 register settings",
             frames_checked, voice_updates);
    $display("run: spans 0..64511, voice counts 0..511, wet mix 0..131071, gain 0..65535");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
